@@ sv/sss_pkg.sv @@
`timescale 1ns / 1ps

package sss_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_BITS = 24;

    localparam int SMP_W     = 24;
    localparam int CNT_OUT_W = 17;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 63;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int DIFF_W    = SMP_W + 1;
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SMP_SHIFT = SMP_W - SAMPLE_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SMP_W-1:0] min_val;
        logic signed [SMP_W-1:0] max_val;
        logic [SMP_W-1:0]        peak;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic signed [SMP_W-1:0] prev;
        logic [DIFF_W-1:0]       dmax;
        logic                    ovf;
    } t_stats;

    localparam t_stats STATS_CLEAR = '{
        count:   '0,
        min_val: {1'b0, {(SMP_W-1){1'b1}}},
        max_val: {1'b1, {(SMP_W-1){1'b0}}},
        peak:    '0,
        sum:     '0,
        sq:      '0,
        prev:    '0,
        dmax:    '0,
        ovf:     1'b0
    };

endpackage

@@ sv/sss_front.sv @@
`timescale 1ns / 1ps

module sss_front import sss_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SMP_W-1:0]     i_sample,
    input  logic                 i_last,
    output logic                 o_push,
    output t_stats               o_rec,
    input  logic                 i_full
);

    logic                    r_a_valid;
    logic                    r_a_last;
    logic signed [SMP_W-1:0] r_a_s;
    logic [PROD_W-1:0]       r_a_prod;
    t_stats                  r_st;
    t_stats                  n_st;
    t_stats                  n_upd;

    logic                    a_go;
    logic [SMP_W-1:0]        in_shl;
    logic signed [SMP_W-1:0] in_s;
    logic [SMP_W-1:0]        in_abs;
    logic [SMP_W-1:0]        a_abs;
    logic [DIFF_W-1:0]       d;
    logic [DIFF_W-1:0]       d_abs;

    always_comb begin
        in_shl = i_sample << SMP_SHIFT;
        in_s   = $signed(in_shl) >>> SMP_SHIFT;
        in_abs = in_s[SMP_W-1] ? (~in_s + 1'b1) : in_s;
    end

    assign a_go    = !r_a_last || !i_full;
    assign o_ready = !r_a_valid || a_go;
    assign o_push  = r_a_valid && r_a_last && a_go;
    assign o_rec   = n_upd;

    always_comb begin
        a_abs = r_a_s[SMP_W-1] ? (~r_a_s + 1'b1) : r_a_s;
        d     = {r_a_s[SMP_W-1], r_a_s} - {r_st.prev[SMP_W-1], r_st.prev};
        d_abs = d[DIFF_W-1] ? (~d + 1'b1) : d;

        n_upd = r_st;
        if (r_st.count == CNT_W'(MAX_SAMPLES)) begin
            n_upd.ovf = 1'b1;
        end else begin
            if ((r_st.count != '0) && (d_abs > r_st.dmax)) begin
                n_upd.dmax = d_abs;
            end
            if ($signed(r_a_s) < $signed(r_st.min_val)) begin
                n_upd.min_val = r_a_s;
            end
            if ($signed(r_a_s) > $signed(r_st.max_val)) begin
                n_upd.max_val = r_a_s;
            end
            if (a_abs > r_st.peak) begin
                n_upd.peak = a_abs;
            end
            n_upd.sum   = $signed(r_st.sum) + $signed(SUM_W'(r_a_s));
            n_upd.sq    = r_st.sq + SQ_W'(r_a_prod);
            n_upd.prev  = r_a_s;
            n_upd.count = r_st.count + 1'b1;
        end
        n_st = r_a_last ? STATS_CLEAR : n_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_last  <= 1'b0;
            r_st      <= STATS_CLEAR;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
                if (i_valid) begin
                    r_a_last <= i_last;
                end
            end
            if (r_a_valid && a_go) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_s    <= in_s;
            r_a_prod <= PROD_W'(in_abs) * PROD_W'(in_abs);
        end
    end

endmodule

@@ sv/sss_queue.sv @@
`timescale 1ns / 1ps

module sss_queue import sss_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_stats i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_stats o_data,
    output logic   o_empty
);

    t_stats              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/sss_back.sv @@
`timescale 1ns / 1ps

module sss_back import sss_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_stats                  i_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CNT_OUT_W-1:0]    o_sample_count,
    output logic signed [SMP_W-1:0] o_minimum,
    output logic signed [SMP_W-1:0] o_maximum,
    output logic [SMP_W-1:0]        o_peak_absolute,
    output logic signed [SMP_W-1:0] o_mean,
    output logic [SMP_W-1:0]        o_rms,
    output logic [SMP_W-1:0]        o_max_first_difference,
    output logic                    o_status
);

    localparam int DIV_W    = 64;
    localparam int STEP_W   = $clog2(DIV_W);
    localparam int ROOT_W   = PROD_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVM = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state;
    t_stats                  r_rec;
    logic                    r_neg;
    logic [DIV_W-1:0]        r_q;
    logic [CNT_W-1:0]        r_rem;
    logic [STEP_W-1:0]       r_step;
    logic [SMP_W-1:0]        r_mean;
    logic [ROOT_W-1:0]       r_x;
    logic [ROOT_W-1:0]       r_root;
    logic [ROOT_W-1:0]       r_bit;

    logic                    r_out_valid;
    logic [CNT_OUT_W-1:0]    r_o_count;
    logic signed [SMP_W-1:0] r_o_min;
    logic signed [SMP_W-1:0] r_o_max;
    logic [SMP_W-1:0]        r_o_peak;
    logic signed [SMP_W-1:0] r_o_mean;
    logic [SMP_W-1:0]        r_o_rms;
    logic [SMP_W-1:0]        r_o_dmax;
    logic                    r_o_status;

    logic [SUM_W-1:0]        sum_mag;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          divisor;
    logic                    ge;
    logic [CNT_W:0]          rem_sub;
    logic [CNT_W-1:0]        rem_nx;
    logic [DIV_W-1:0]        q_nx;
    logic [SMP_W-1:0]        mean_mag;
    logic [ROOT_W-1:0]       trial;
    logic                    take;
    logic [ROOT_W-1:0]       x_nx;
    logic [ROOT_W-1:0]       root_nx;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        sum_mag  = i_data.sum[SUM_W-1] ? (~i_data.sum + 1'b1) : i_data.sum;
        rem_sh   = {r_rem, r_q[DIV_W-1]};
        divisor  = {1'b0, r_rec.count};
        ge       = (rem_sh >= divisor);
        rem_sub  = ge ? (rem_sh - divisor) : rem_sh;
        rem_nx   = rem_sub[CNT_W-1:0];
        q_nx     = {r_q[DIV_W-2:0], ge};
        mean_mag = q_nx[SMP_W-1:0];
        trial    = r_root + r_bit;
        take     = (r_x >= trial);
        x_nx     = take ? (r_x - trial) : r_x;
        root_nx  = take ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_DIVM;
                    end
                end
                S_DIVM: begin
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rec  <= i_data;
                r_neg  <= i_data.sum[SUM_W-1];
                r_q    <= DIV_W'(sum_mag);
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIVM: begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_mean <= r_neg ? (~mean_mag + 1'b1) : mean_mag;
                    r_q    <= DIV_W'(r_rec.sq);
                    r_rem  <= '0;
                end else begin
                    r_q    <= q_nx;
                    r_rem  <= rem_nx;
                end
            end
            S_DIVS: begin
                r_q    <= q_nx;
                r_rem  <= rem_nx;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    r_x    <= q_nx[ROOT_W-1:0];
                    r_root <= '0;
                    r_bit  <= ROOT_W'(1) << (ROOT_W - 2);
                end
            end
            S_SQRT: begin
                r_x    <= x_nx;
                r_root <= root_nx;
                r_bit  <= r_bit >> 2;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_o_count  <= CNT_OUT_W'(r_rec.count);
                    r_o_min    <= r_rec.min_val;
                    r_o_max    <= r_rec.max_val;
                    r_o_peak   <= r_rec.peak;
                    r_o_mean   <= r_mean;
                    r_o_rms    <= r_root[SMP_W-1:0];
                    r_o_dmax   <= r_rec.dmax[SMP_W-1:0];
                    r_o_status <= r_rec.ovf;
                end
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

    assign o_valid                = r_out_valid;
    assign o_sample_count         = r_o_count;
    assign o_minimum              = r_o_min;
    assign o_maximum              = r_o_max;
    assign o_peak_absolute        = r_o_peak;
    assign o_mean                 = r_o_mean;
    assign o_rms                  = r_o_rms;
    assign o_max_first_difference = r_o_dmax;
    assign o_status               = r_o_status;

endmodule

@@ sv/sample_stream_statistics.sv @@
`timescale 1ns / 1ps
// Running statistics over records of signed 24-bit samples.
// Input channel (i_in_valid / o_in_ready): one sample per transaction, i_last
// marks the final sample of a record. Output channel (o_out_valid /
// i_out_ready): one transaction per record with count, min, max, peak,
// mean, rms, largest first difference and an overflow status.
// Samples are taken at one per cycle while o_in_ready is high: a register
// stage forms the square, which is then folded into the running totals.
// A finished record enters a two-entry queue; the back end divides sum and
// sum of squares by the count (one quotient bit per cycle) and takes the
// square root. The back end works on one record at a time, so records
// shorter than its processing time stall the input once the queue fills.
// Records longer than 65536 samples saturate the count and flag status.
// While i_out_ready is low the result holds, the back end stops after its
// current record, and the input stalls once the queue is full.
// Synchronous reset clears the running statistics, the queue and the output valid.

module sample_stream_statistics import sss_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SMP_W-1:0]        i_sample,
    input  logic                    i_last,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CNT_OUT_W-1:0]    o_sample_count,
    output logic signed [SMP_W-1:0] o_minimum,
    output logic signed [SMP_W-1:0] o_maximum,
    output logic [SMP_W-1:0]        o_peak_absolute,
    output logic signed [SMP_W-1:0] o_mean,
    output logic [SMP_W-1:0]        o_rms,
    output logic [SMP_W-1:0]        o_max_first_difference,
    output logic                    o_status
);

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    t_stats rec_in;
    t_stats rec_out;
    logic [SMP_W-1:0] mean_abs;

    sss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_sample),
        .i_last   (i_last),
        .o_push   (push),
        .o_rec    (rec_in),
        .i_full   (full)
    );

    sss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (rec_out),
        .o_empty (empty)
    );

    sss_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_empty                (empty),
        .i_data                 (rec_out),
        .o_pop                  (pop),
        .o_valid                (o_out_valid),
        .i_ready                (i_out_ready),
        .o_sample_count         (o_sample_count),
        .o_minimum              (o_minimum),
        .o_maximum              (o_maximum),
        .o_peak_absolute        (o_peak_absolute),
        .o_mean                 (o_mean),
        .o_rms                  (o_rms),
        .o_max_first_difference (o_max_first_difference),
        .o_status               (o_status)
    );

    assign mean_abs = o_mean[SMP_W-1] ? (~o_mean + 1'b1) : o_mean;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("record pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != '0) && (o_sample_count <= MAX_SAMPLES))
        else $error("sample count out of range");

    a_status_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_sample_count == MAX_SAMPLES))
        else $error("overflow status without saturated count");

    a_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_minimum <= o_maximum) && (o_rms <= o_peak_absolute)
                        && (o_rms >= mean_abs))
        else $error("inconsistent record statistics");

endmodule
